/* src/peps_pkg.sv */
package peps_pkg;

   // Device address width
   localparam int ADDR_BITS = 15;
   // Widths of the fixed fields
   localparam int DATA_W    = 8;
   localparam int COUNT_W   = 16;
   localparam int SIZE_W    = 16;
   localparam int PB_W      = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;
   localparam int CMP_W     = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

   // Request actions
   localparam logic [1:0] ACT_READ   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_VERIFY = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_WAIT   = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_READ_ONLY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SDP_ENABLE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SDP_DISABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_BITS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAGE_WAIT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ADDRESS_MASK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEVICE_SIZE  = 3'd6;

   // Command addresses and bytes of the protection scheme
   localparam logic [15:0] CMD_A = 16'h5555;
   localparam logic [15:0] CMD_B = 16'h2AAA;
   localparam logic [DATA_W-1:0] CMD_UNLOCK0 = 8'hAA;
   localparam logic [DATA_W-1:0] CMD_UNLOCK1 = 8'h55;
   localparam logic [DATA_W-1:0] CMD_PROGRAM = 8'hA0;
   localparam logic [DATA_W-1:0] CMD_ERASE   = 8'h80;
   localparam logic [DATA_W-1:0] CMD_DISABLE = 8'h20;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h8000;

   // Result slots of one request, issued lowest first
   localparam int NUM_STEPS = 13;
   localparam int STEP_W    = 4;
   localparam logic [STEP_W-1:0] STEP_DIS0     = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DIS1     = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIS2     = 4'd2;
   localparam logic [STEP_W-1:0] STEP_DIS3     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_DIS4     = 4'd4;
   localparam logic [STEP_W-1:0] STEP_DIS5     = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DIS_WAIT = 4'd6;
   localparam logic [STEP_W-1:0] STEP_PG_WAIT  = 4'd7;
   localparam logic [STEP_W-1:0] STEP_UNL0     = 4'd8;
   localparam logic [STEP_W-1:0] STEP_UNL1     = 4'd9;
   localparam logic [STEP_W-1:0] STEP_UNL2     = 4'd10;
   localparam logic [STEP_W-1:0] STEP_MAIN     = 4'd11;
   localparam logic [STEP_W-1:0] STEP_FINAL    = 4'd12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic                 read_only;
      logic                 sdp_enable;
      logic                 sdp_disable_on_start;
      logic [PB_W-1:0]      page_bits;
      logic [DATA_W-1:0]    page_wait_ms;
      logic [ADDR_BITS-1:0] address_mask;
      logic [SIZE_W-1:0]    device_size;
   } cfg_type;

   // One classified request as the back end needs it
   typedef struct packed {
      logic [1:0]           kind;
      logic [ADDR_BITS-1:0] bus_address;
      logic [DATA_W-1:0]    bus_data;
      logic                 mismatch;
      logic [COUNT_W-1:0]   error_count;
      logic [NUM_STEPS-1:0] steps;
   } job_type;

   // Command byte of a protection-sequence slot
   function automatic logic [DATA_W-1:0] step_data(input logic [STEP_W-1:0] step);
      logic [DATA_W-1:0] d;
      case (step)
         STEP_DIS0, STEP_DIS3, STEP_UNL0: d = CMD_UNLOCK0;
         STEP_DIS1, STEP_DIS4, STEP_UNL1: d = CMD_UNLOCK1;
         STEP_DIS2:                       d = CMD_ERASE;
         STEP_DIS5:                       d = CMD_DISABLE;
         STEP_UNL2:                       d = CMD_PROGRAM;
         default:                         d = '0;
      endcase
      return d;
   endfunction

   // Command address of a protection-sequence slot
   function automatic logic [ADDR_BITS-1:0] step_addr(input logic [STEP_W-1:0] step);
      logic [ADDR_BITS-1:0] a;
      case (step)
         STEP_DIS1, STEP_DIS4, STEP_UNL1: a = ADDR_BITS'(CMD_B);
         default:                         a = ADDR_BITS'(CMD_A);
      endcase
      return a;
   endfunction

endpackage

/* src/peps_front.sv */
module peps_front import peps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [DATA_W-1:0]    req_data,
   input  logic [DATA_W-1:0]    req_sample,
   input  logic                 req_first,
   input  logic                 req_last,
   output logic                 job_valid,
   input  logic                 job_ready,
   output job_type              job
);

   logic [COUNT_W-1:0]   mismatch_count_ff;
   logic [COUNT_W-1:0]   mismatch_count_in;
   logic [COUNT_W-1:0]   count_base;
   logic [COUNT_W-1:0]   count_next;
   logic [ADDR_BITS-1:0] page_low;
   logic [ADDR_BITS-1:0] bus_addr;
   logic                 reject;
   logic                 differs;
   logic                 page_start;
   logic                 disable_seq;
   logic                 has_wait;
   logic                 accept;

   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && req_ready;

   // Classify the request
   always_comb begin
      for (int i = 0; i < ADDR_BITS; i++) begin
         page_low[i] = (i < int'(cfg.page_bits));
      end
      bus_addr    = req_address | cfg.address_mask;
      reject      = (req_action != ACT_READ && req_action != ACT_WRITE &&
                     req_action != ACT_VERIFY) ||
                    (CMP_W'(req_address) >= CMP_W'(cfg.device_size)) ||
                    (req_action == ACT_WRITE && cfg.read_only);
      differs     = (req_sample != req_data);
      page_start  = (cfg.page_bits != '0) && ((req_address & page_low) == '0);
      disable_seq = req_first && cfg.sdp_disable_on_start;
      has_wait    = (cfg.page_wait_ms != '0);
      count_base  = req_first ? '0 : mismatch_count_ff;
      count_next  = (differs && count_base < COUNT_MAX) ? count_base + 1'b1 : count_base;
   end

   // Build the job descriptor
   always_comb begin
      job             = '0;
      job.steps[STEP_MAIN] = 1'b1;
      if (reject) begin
         job.kind = KIND_REJECT;
      end else if (req_action == ACT_READ) begin
         job.kind        = KIND_READ;
         job.bus_address = bus_addr;
         job.bus_data    = req_sample;
      end else if (req_action == ACT_VERIFY) begin
         job.kind        = KIND_READ;
         job.bus_address = bus_addr;
         job.bus_data    = req_sample;
         job.mismatch    = differs;
         job.error_count = count_next;
      end else begin
         job.kind        = KIND_WRITE;
         job.bus_address = bus_addr;
         job.bus_data    = req_data;
         job.steps[STEP_DIS0]     = disable_seq;
         job.steps[STEP_DIS1]     = disable_seq;
         job.steps[STEP_DIS2]     = disable_seq;
         job.steps[STEP_DIS3]     = disable_seq;
         job.steps[STEP_DIS4]     = disable_seq;
         job.steps[STEP_DIS5]     = disable_seq;
         job.steps[STEP_DIS_WAIT] = disable_seq && has_wait;
         job.steps[STEP_PG_WAIT]  = page_start && has_wait;
         job.steps[STEP_UNL0]     = page_start && cfg.sdp_enable;
         job.steps[STEP_UNL1]     = page_start && cfg.sdp_enable;
         job.steps[STEP_UNL2]     = page_start && cfg.sdp_enable;
         job.steps[STEP_FINAL]    = req_last && has_wait;
      end
   end

   // Advance the session mismatch count on an accepted verify
   always_comb begin
      mismatch_count_in = mismatch_count_ff;
      if (accept && !reject && req_action == ACT_VERIFY) begin
         mismatch_count_in = count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_count_ff <= '0;
      end else begin
         mismatch_count_ff <= mismatch_count_in;
      end
   end

endmodule

/* src/peps_queue.sv */
module peps_queue import peps_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  job_type in_job,
   output logic    out_valid,
   input  logic    out_ready,
   output job_type out_job
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              push;
   logic              pop;

   assign in_ready  = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_job   = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Move pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_job;
      end
   end

endmodule

/* src/peps_back.sv */
module peps_back import peps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  job_type               job,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [ADDR_BITS-1:0]  rsp_bus_address,
   output logic [DATA_W-1:0]     rsp_bus_data,
   output logic [DATA_W-1:0]     rsp_wait_ms,
   output logic                  rsp_mismatch,
   output logic [COUNT_W-1:0]    rsp_error_count,
   output logic                  rsp_last_of_run
);

   job_type              cur_ff, cur_in;
   logic [NUM_STEPS-1:0] mask_ff, mask_in;
   logic                 act_ff, act_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [DATA_W-1:0]    data_ff, data_in;
   logic [DATA_W-1:0]    wait_ff, wait_in;
   logic                 mis_ff, mis_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 last_ff, last_in;
   logic [STEP_W-1:0]    step;
   logic [NUM_STEPS-1:0] rest;
   logic                 final_step;
   logic                 advance;
   logic                 pop;

   // Pick the lowest pending slot
   always_comb begin
      step = '0;
      for (int i = NUM_STEPS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            step = STEP_W'(i);
         end
      end
      rest       = mask_ff & (mask_ff - 1'b1);
      final_step = (rest == '0);
      advance    = act_ff && (!rsp_valid_ff || rsp_ready);
      pop        = job_valid && (!act_ff || (advance && final_step));
   end

   assign job_ready = pop;

   // Format the result of the chosen slot
   always_comb begin
      kind_in = KIND_WRITE;
      addr_in = step_addr(step) | cfg.address_mask;
      data_in = step_data(step);
      wait_in = '0;
      mis_in  = 1'b0;
      cnt_in  = '0;
      last_in = final_step;
      case (step)
         STEP_DIS_WAIT, STEP_PG_WAIT, STEP_FINAL: begin
            kind_in = KIND_WAIT;
            addr_in = '0;
            data_in = '0;
            wait_in = cfg.page_wait_ms;
         end
         STEP_MAIN: begin
            kind_in = cur_ff.kind;
            addr_in = cur_ff.bus_address;
            data_in = cur_ff.bus_data;
            mis_in  = cur_ff.mismatch;
            cnt_in  = cur_ff.error_count;
         end
         default: begin
         end
      endcase
   end

   // Load the next job or retire slots of the current one
   always_comb begin
      cur_in  = pop ? job : cur_ff;
      mask_in = mask_ff;
      act_in  = act_ff;
      if (pop) begin
         mask_in = job.steps;
         act_in  = 1'b1;
      end else if (advance) begin
         mask_in = rest;
         act_in  = !final_step;
      end
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         act_ff       <= act_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the job and the output register
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (advance) begin
         kind_ff <= kind_in;
         addr_ff <= addr_in;
         data_ff <= data_in;
         wait_ff <= wait_in;
         mis_ff  <= mis_in;
         cnt_ff  <= cnt_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_bus_address = addr_ff;
   assign rsp_bus_data    = data_ff;
   assign rsp_wait_ms     = wait_ff;
   assign rsp_mismatch    = mis_ff;
   assign rsp_error_count = cnt_ff;
   assign rsp_last_of_run = last_ff;

endmodule

/* src/parallel_eeprom_program_sequencer_top.sv */
// Program sequencer for a byte-wide parallel EEPROM with software data
// protection. Each request (read, write or verify of one byte) yields one to
// thirteen responses: bus write cycles, bus read cycles, waits or a single
// reject, the last one flagged by rsp_last_of_run. The front end classifies a
// request in the cycle it is accepted and queues it (four deep); the back end
// issues one response per clock from that queue into an output register
// unless rsp_ready stalls it; a request holds the back end until its last
// response is issued, and plain reads, verifies and mid-page writes run at one
// request per clock. Write the registers only while no request is in flight.
module parallel_eeprom_program_sequencer_top import peps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_action,
   input  logic [ADDR_BITS-1:0] req_address,
   input  logic [DATA_W-1:0]    req_data,
   input  logic [DATA_W-1:0]    req_sample,
   input  logic                 req_first,
   input  logic                 req_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [ADDR_BITS-1:0] rsp_bus_address,
   output logic [DATA_W-1:0]    rsp_bus_data,
   output logic [DATA_W-1:0]    rsp_wait_ms,
   output logic                 rsp_mismatch,
   output logic [COUNT_W-1:0]   rsp_error_count,
   output logic                 rsp_last_of_run
);

   cfg_type cfg_ff, cfg_in;
   job_type front_job, queue_job;
   logic    front_valid, front_ready;
   logic    queue_valid, queue_ready;

   // Apply register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_READ_ONLY:    cfg_in.read_only            = csr_wdata[0];
            REG_SDP_ENABLE:   cfg_in.sdp_enable           = csr_wdata[0];
            REG_SDP_DISABLE:  cfg_in.sdp_disable_on_start = csr_wdata[0];
            REG_PAGE_BITS:    cfg_in.page_bits            = csr_wdata[PB_W-1:0];
            REG_PAGE_WAIT:    cfg_in.page_wait_ms         = csr_wdata[DATA_W-1:0];
            REG_ADDRESS_MASK: cfg_in.address_mask         = csr_wdata[ADDR_BITS-1:0];
            REG_DEVICE_SIZE:  cfg_in.device_size          = csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.read_only            <= 1'b0;
         cfg_ff.sdp_enable           <= 1'b0;
         cfg_ff.sdp_disable_on_start <= 1'b0;
         cfg_ff.page_bits            <= PB_W'(6);
         cfg_ff.page_wait_ms         <= DATA_W'(10);
         cfg_ff.address_mask         <= '0;
         cfg_ff.device_size          <= SIZE_W'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   peps_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_action  (req_action),
      .req_address (req_address),
      .req_data    (req_data),
      .req_sample  (req_sample),
      .req_first   (req_first),
      .req_last    (req_last),
      .job_valid   (front_valid),
      .job_ready   (front_ready),
      .job         (front_job)
   );

   peps_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_job    (front_job),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_job   (queue_job)
   );

   peps_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .job_valid       (queue_valid),
      .job_ready       (queue_ready),
      .job             (queue_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_data    (rsp_bus_data),
      .rsp_wait_ms     (rsp_wait_ms),
      .rsp_mismatch    (rsp_mismatch),
      .rsp_error_count (rsp_error_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
